>>> src/wss_pkg.sv
package wss_pkg;

  // Channel field widths
  localparam int OP_W       = 2;
  localparam int COL_SEL_W  = 6;
  localparam int ENTRY_W    = 10;
  localparam int SAMPLE_W   = 16;
  localparam int OUT_W      = 17;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_SIZE_LOG2  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_STEP         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_CYCLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_POSITION    = 3'd5;

  localparam int COUNT_W    = 7;
  localparam int LOG2_W     = 4;
  localparam int PHASE_W    = 32;
  localparam int SCAN_W     = 25;
  localparam int SPC_W      = 13;
  localparam int CNT_W      = 12;
  localparam int FRAC_W     = 16;

  localparam logic [SCAN_W-1:0] SCAN_ONE    = 25'h1000000;
  localparam logic [SPC_W-1:0]  SPC_MAX     = 13'd4096;
  localparam logic [LOG2_W-1:0] LOG2_RESET  = 4'd8;
  localparam logic [SPC_W-1:0]  SPC_RESET   = 13'd256;

  // Shared multiply-accumulate unit
  localparam int MAC_A_W = 36;
  localparam int MAC_B_W = 18;
  localparam int PROD_W  = MAC_A_W + MAC_B_W;
  localparam int ACC_W   = 48;

  // Divider: quotient of the biased sample, dividend always below 2^30
  localparam int QUO_W  = 17;
  localparam int DIVD_W = 30;
  localparam int REM_W  = SPC_W;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    logic signed [MAC_A_W-1:0] op_a;
    logic signed [MAC_B_W-1:0] op_b;
    acc_op_t                   acc_op;
  } mac_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COLA,
    ST_COLB,
    ST_RDA0,
    ST_RDA1,
    ST_RDB0,
    ST_RDB1,
    ST_VB0,
    ST_VB1,
    ST_MIX0,
    ST_MIX1,
    ST_DIVLD,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

>>> src/wss_in_if.sv
interface wss_in_if;
  logic                                valid;
  logic                                ready;
  logic [wss_pkg::OP_W-1:0]            operation;
  logic [wss_pkg::COL_SEL_W-1:0]       column_select;
  logic [wss_pkg::ENTRY_W-1:0]         entry_index;
  logic signed [wss_pkg::SAMPLE_W-1:0] table_value;

  modport source (output valid, operation, column_select, entry_index, table_value,
                  input ready);
  modport sink   (input valid, operation, column_select, entry_index, table_value,
                  output ready);
endinterface

>>> src/wss_out_if.sv
interface wss_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [wss_pkg::OUT_W-1:0] sample_out;
  logic                             cycle_end;

  modport source (output valid, sample_out, cycle_end, input ready);
  modport sink   (input valid, sample_out, cycle_end, output ready);
endinterface

>>> src/wss_table.sv
module wss_table #(
  parameter int AW = 16
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [AW-1:0]                       waddr,
  input  logic signed [wss_pkg::SAMPLE_W-1:0] wdata,
  input  logic [AW-1:0]                       raddr,
  output logic signed [wss_pkg::SAMPLE_W-1:0] rdata
);

  logic signed [wss_pkg::SAMPLE_W-1:0] mem [2**AW];
  logic signed [wss_pkg::SAMPLE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/wss_mac.sv
module wss_mac (
  input  logic                                    clk,
  input  wss_pkg::mac_cmd_t                       cmd,
  output logic signed [wss_pkg::PROD_W-1:0]       prod,
  output logic signed [wss_pkg::ACC_W-1:0]        acc
);

  logic signed [wss_pkg::PROD_W-1:0] prod_r;
  logic signed [wss_pkg::ACC_W-1:0]  acc_r;

  always_ff @(posedge clk) begin
    prod_r <= cmd.op_a * cmd.op_b;
    unique case (cmd.acc_op)
      wss_pkg::ACC_LOAD: acc_r <= prod_r[wss_pkg::ACC_W-1:0];
      wss_pkg::ACC_ADD:  acc_r <= acc_r + prod_r[wss_pkg::ACC_W-1:0];
      default:           acc_r <= acc_r;
    endcase
  end

  assign prod = prod_r;
  assign acc  = acc_r;

endmodule

>>> src/wss_div.sv
module wss_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [wss_pkg::DIVD_W-1:0]    dividend,
  input  logic [wss_pkg::SPC_W-1:0]     divisor,
  output logic                          busy,
  output logic [wss_pkg::QUO_W-1:0]     quotient
);

  localparam int STEP_W = $clog2(wss_pkg::QUO_W + 1);

  logic [wss_pkg::REM_W-1:0] rem_r;
  logic [wss_pkg::QUO_W-1:0] quo_r;
  logic [STEP_W-1:0]         step_r;
  logic                      busy_r;
  logic [wss_pkg::REM_W:0]   trial;
  logic                      ge;

  // One quotient bit per cycle; the top bits of the dividend are already below the divisor
  assign trial = {rem_r, quo_r[wss_pkg::QUO_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= STEP_W'(wss_pkg::QUO_W);
    end else if (busy_r) begin
      step_r <= step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[wss_pkg::DIVD_W-1:wss_pkg::QUO_W];
      quo_r <= dividend[wss_pkg::QUO_W-1:0];
    end else if (busy_r) begin
      rem_r <= ge ? wss_pkg::REM_W'(trial - {1'b0, divisor}) : wss_pkg::REM_W'(trial);
      quo_r <= {quo_r[wss_pkg::QUO_W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

>>> src/wavetable_scan_oscillator.sv
// Wavetable scan oscillator.
// in_ch carries transactions: table writes, note start, note stop and sample
// ticks. Writes, start and stop complete in the cycle they are accepted and
// in_ch.ready stays high. A tick while playing with two or more columns makes
// one result on out_ch: the interpolated, crossfaded and doubled sample plus a
// cycle_end flag. Such a tick keeps in_ch.ready low through its steps on the
// shared multiply-accumulate unit and table read port, in the one-bit-per-cycle
// divider and in the load of the output register. A tick that makes no result
// completes in the cycle it is accepted.
// The result sits in an output register until taken; the next transaction can
// be accepted meanwhile, and a following tick holds in its last step while the
// receiver stalls.
// cfg_we/cfg_index/cfg_data write one register per cycle; write only when idle.
// Reset (rst_n low, synchronous) restores the register defaults, stops the
// note and empties the output register. The table is not cleared; entries
// must be written before a note reads them.
module wavetable_scan_oscillator #(
  parameter int MAX_COLUMNS     = 64,
  parameter int MAX_COLUMN_SIZE = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  wss_in_if.sink                            in_ch,
  wss_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [wss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wss_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CB   = $clog2(MAX_COLUMNS);
  localparam int IB   = $clog2(MAX_COLUMN_SIZE);
  localparam int AW   = CB + IB;
  localparam int CNTW = $clog2(MAX_COLUMNS + 1);
  localparam int LMAX = $clog2(MAX_COLUMN_SIZE + 1) - 1;

  // Configuration registers
  logic [wss_pkg::COUNT_W-1:0] col_count_r;
  logic [wss_pkg::LOG2_W-1:0]  size_log2_r;
  logic [wss_pkg::PHASE_W-1:0] phase_step_r;
  logic [wss_pkg::SCAN_W-1:0]  scan_step_r;
  logic [wss_pkg::SPC_W-1:0]   spc_r;
  logic [wss_pkg::SCAN_W-1:0]  start_pos_r;

  // Voice state
  wss_pkg::state_t             state_r, state_nxt;
  logic [wss_pkg::PHASE_W-1:0] phase_r;
  logic [wss_pkg::SCAN_W-1:0]  pos_r;
  logic [wss_pkg::CNT_W-1:0]   cnt_r;
  logic                        playing_r;

  // Per-tick work registers
  logic [IB-1:0]               idx_r, nidx_r;
  logic [wss_pkg::FRAC_W-1:0]  f_r;
  logic [wss_pkg::SPC_W-1:0]   n_r;
  logic [wss_pkg::CNT_W-1:0]   i_r;
  logic [CNTW-1:0]             cols_r;
  logic [CB-1:0]               ca_r, cb_r;
  logic signed [wss_pkg::MAC_A_W-1:0] va_r;

  logic                              out_valid_r;
  logic signed [wss_pkg::OUT_W-1:0]  sample_r;
  logic                              cycle_end_r;

  // Datapath links
  wss_pkg::mac_cmd_t                   mac_cmd;
  logic signed [wss_pkg::PROD_W-1:0]   prod;
  logic signed [wss_pkg::ACC_W-1:0]    acc;
  logic signed [wss_pkg::SAMPLE_W-1:0] rdata;
  logic [AW-1:0]                       raddr;
  logic                                mem_we;
  logic [AW-1:0]                       waddr;
  logic                                div_start;
  logic                                div_busy;
  logic [wss_pkg::QUO_W-1:0]           quotient;
  logic                                load_out;

  logic                        accept;
  wss_pkg::op_t                op;
  logic [31:0]                 wcol32, widx32;
  logic                        wr_in_range;
  logic [31:0]                 cols32;
  logic [CNTW-1:0]             cols_c;
  logic                        tick_go;
  logic [wss_pkg::LOG2_W-1:0]  l_eff;
  logic [31:0]                 idx32, nidx32, mask32, frac32;
  logic [wss_pkg::SPC_W-1:0]   n_c;
  logic [wss_pkg::CNT_W-1:0]   i_c;
  logic [29:0]                 pick_raw, pick_lim;
  logic [CB-1:0]               pick_c;
  logic [wss_pkg::SCAN_W:0]    pos_sum;
  logic [wss_pkg::SCAN_W-1:0]  pos_sat;
  logic [wss_pkg::SCAN_W-1:0]  start_sat;
  logic [wss_pkg::FRAC_W:0]    f_comp;
  logic [wss_pkg::ACC_W-1:0]   num_c;
  logic                        end_c;

  assign accept = in_ch.valid && in_ch.ready;
  assign op     = wss_pkg::op_t'(in_ch.operation);

  // Table write address
  assign wcol32      = 32'(in_ch.column_select);
  assign widx32      = 32'(in_ch.entry_index);
  assign wr_in_range = (wcol32 < 32'(MAX_COLUMNS)) && (widx32 < 32'(MAX_COLUMN_SIZE));
  assign waddr       = {wcol32[CB-1:0], widx32[IB-1:0]};

  assign cols32  = (32'(col_count_r) > 32'(MAX_COLUMNS)) ? 32'(MAX_COLUMNS)
                                                         : 32'(col_count_r);
  assign cols_c  = CNTW'(cols32);
  assign tick_go = playing_r && (cols32 >= 32'd2);

  // Phase split into entry index and 16-bit fraction
  always_comb begin
    if (size_log2_r < 4'd1) begin
      l_eff = 4'd1;
    end else if (size_log2_r > wss_pkg::LOG2_W'(LMAX)) begin
      l_eff = wss_pkg::LOG2_W'(LMAX);
    end else begin
      l_eff = size_log2_r;
    end
  end

  assign idx32  = phase_r >> (6'd32 - 6'(l_eff));
  assign mask32 = (32'd1 << l_eff) - 32'd1;
  assign nidx32 = (idx32 + 32'd1) & mask32;
  assign frac32 = phase_r << l_eff;

  always_comb begin
    if (spc_r == '0) begin
      n_c = wss_pkg::SPC_W'(1);
    end else if (spc_r > wss_pkg::SPC_MAX) begin
      n_c = wss_pkg::SPC_MAX;
    end else begin
      n_c = spc_r;
    end
  end

  // A counter left past a lowered cycle length counts as the last sample
  assign i_c = (wss_pkg::SPC_W'(cnt_r) >= n_c) ? wss_pkg::CNT_W'(n_c - 1'b1) : cnt_r;

  // Column pick from the registered product pos * cols, clamped to cols-1
  assign pick_raw = prod[wss_pkg::PROD_W-1:24];
  assign pick_lim = 30'(cols_r) - 30'd1;
  assign pick_c   = (pick_raw > pick_lim) ? pick_lim[CB-1:0] : pick_raw[CB-1:0];

  assign pos_sum   = {1'b0, pos_r} + {1'b0, scan_step_r};
  assign pos_sat   = (pos_sum > {1'b0, wss_pkg::SCAN_ONE}) ? wss_pkg::SCAN_ONE
                                                           : pos_sum[wss_pkg::SCAN_W-1:0];
  assign start_sat = (start_pos_r > wss_pkg::SCAN_ONE) ? wss_pkg::SCAN_ONE : start_pos_r;

  assign f_comp = (wss_pkg::FRAC_W+1)'(1 << wss_pkg::FRAC_W) - {1'b0, f_r};

  // Rounded blend biased by 2^16 * n so that the divider sees a non-negative value:
  // 2*blend + n*2^15 + n*2^32, then drop 16 bits
  assign num_c = {acc[wss_pkg::ACC_W-2:0], 1'b0}
               + (wss_pkg::ACC_W'(n_r) << 15)
               + (wss_pkg::ACC_W'(n_r) << 32);

  assign end_c = (wss_pkg::SPC_W'(i_r) + 1'b1) >= n_r;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wss_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_ch.ready    = (state_r == wss_pkg::ST_IDLE);
    mac_cmd.op_a   = '0;
    mac_cmd.op_b   = '0;
    mac_cmd.acc_op = wss_pkg::ACC_HOLD;
    raddr          = {ca_r, idx_r};
    mem_we         = 1'b0;
    div_start      = 1'b0;
    load_out       = 1'b0;

    unique case (state_r)
      wss_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          if (op == wss_pkg::OP_WRITE) begin
            mem_we = wr_in_range;
          end
          if (op == wss_pkg::OP_TICK && tick_go) begin
            state_nxt = wss_pkg::ST_COLA;
          end
        end
      end
      wss_pkg::ST_COLA: begin
        mac_cmd.op_a = wss_pkg::MAC_A_W'(pos_r);
        mac_cmd.op_b = wss_pkg::MAC_B_W'(cols_r);
        state_nxt    = wss_pkg::ST_COLB;
      end
      wss_pkg::ST_COLB: begin
        mac_cmd.op_a = wss_pkg::MAC_A_W'(pos_sum);
        mac_cmd.op_b = wss_pkg::MAC_B_W'(cols_r);
        state_nxt    = wss_pkg::ST_RDA0;
      end
      wss_pkg::ST_RDA0: begin
        raddr     = {ca_r, idx_r};
        state_nxt = wss_pkg::ST_RDA1;
      end
      wss_pkg::ST_RDA1: begin
        raddr        = {ca_r, nidx_r};
        mac_cmd.op_a = wss_pkg::MAC_A_W'(rdata);
        mac_cmd.op_b = wss_pkg::MAC_B_W'(f_comp);
        state_nxt    = wss_pkg::ST_RDB0;
      end
      wss_pkg::ST_RDB0: begin
        raddr          = {cb_r, idx_r};
        mac_cmd.op_a   = wss_pkg::MAC_A_W'(rdata);
        mac_cmd.op_b   = wss_pkg::MAC_B_W'(f_r);
        mac_cmd.acc_op = wss_pkg::ACC_LOAD;
        state_nxt      = wss_pkg::ST_RDB1;
      end
      wss_pkg::ST_RDB1: begin
        raddr          = {cb_r, nidx_r};
        mac_cmd.op_a   = wss_pkg::MAC_A_W'(rdata);
        mac_cmd.op_b   = wss_pkg::MAC_B_W'(f_comp);
        mac_cmd.acc_op = wss_pkg::ACC_ADD;
        state_nxt      = wss_pkg::ST_VB0;
      end
      wss_pkg::ST_VB0: begin
        mac_cmd.op_a   = wss_pkg::MAC_A_W'(rdata);
        mac_cmd.op_b   = wss_pkg::MAC_B_W'(f_r);
        mac_cmd.acc_op = wss_pkg::ACC_LOAD;
        state_nxt      = wss_pkg::ST_VB1;
      end
      wss_pkg::ST_VB1: begin
        mac_cmd.op_a   = va_r;
        mac_cmd.op_b   = wss_pkg::MAC_B_W'(n_r - wss_pkg::SPC_W'(i_r));
        mac_cmd.acc_op = wss_pkg::ACC_ADD;
        state_nxt      = wss_pkg::ST_MIX0;
      end
      wss_pkg::ST_MIX0: begin
        mac_cmd.op_a   = acc[wss_pkg::MAC_A_W-1:0];
        mac_cmd.op_b   = wss_pkg::MAC_B_W'(i_r);
        mac_cmd.acc_op = wss_pkg::ACC_LOAD;
        state_nxt      = wss_pkg::ST_MIX1;
      end
      wss_pkg::ST_MIX1: begin
        mac_cmd.acc_op = wss_pkg::ACC_ADD;
        state_nxt      = wss_pkg::ST_DIVLD;
      end
      wss_pkg::ST_DIVLD: begin
        div_start = 1'b1;
        state_nxt = wss_pkg::ST_DIV;
      end
      wss_pkg::ST_DIV: begin
        if (!div_busy) begin
          state_nxt = wss_pkg::ST_EMIT;
        end
      end
      wss_pkg::ST_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = wss_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wss_pkg::ST_IDLE;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r  <= '0;
      size_log2_r  <= wss_pkg::LOG2_RESET;
      phase_step_r <= '0;
      scan_step_r  <= '0;
      spc_r        <= wss_pkg::SPC_RESET;
      start_pos_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wss_pkg::CFG_COLUMN_COUNT:      col_count_r  <= cfg_data[wss_pkg::COUNT_W-1:0];
        wss_pkg::CFG_COLUMN_SIZE_LOG2:  size_log2_r  <= cfg_data[wss_pkg::LOG2_W-1:0];
        wss_pkg::CFG_PHASE_STEP:        phase_step_r <= cfg_data[wss_pkg::PHASE_W-1:0];
        wss_pkg::CFG_SCAN_STEP:         scan_step_r  <= cfg_data[wss_pkg::SCAN_W-1:0];
        wss_pkg::CFG_SAMPLES_PER_CYCLE: spc_r        <= cfg_data[wss_pkg::SPC_W-1:0];
        wss_pkg::CFG_START_POSITION:    start_pos_r  <= cfg_data[wss_pkg::SCAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Voice state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      playing_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        unique case (op)
          wss_pkg::OP_START: begin
            phase_r   <= '0;
            pos_r     <= start_sat;
            cnt_r     <= '0;
            playing_r <= (col_count_r != '0);
          end
          wss_pkg::OP_STOP: playing_r <= 1'b0;
          wss_pkg::OP_TICK: begin
            if (tick_go) begin
              phase_r <= phase_r + phase_step_r;
            end
          end
          default: ;
        endcase
      end

      if (load_out) begin
        out_valid_r <= 1'b1;
        if (end_c) begin
          pos_r <= pos_sat;
          cnt_r <= '0;
        end else begin
          cnt_r <= i_r + 1'b1;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Work registers, loaded at tick acceptance and along the sequence
  always_ff @(posedge clk) begin
    if (accept && op == wss_pkg::OP_TICK) begin
      idx_r  <= idx32[IB-1:0];
      nidx_r <= nidx32[IB-1:0];
      f_r    <= frac32[31:16];
      n_r    <= n_c;
      i_r    <= i_c;
      cols_r <= cols_c;
    end
    if (state_r == wss_pkg::ST_COLB) begin
      ca_r <= pick_c;
    end
    if (state_r == wss_pkg::ST_RDA0) begin
      cb_r <= pick_c;
    end
    if (state_r == wss_pkg::ST_VB0) begin
      va_r <= acc[wss_pkg::MAC_A_W-1:0];
    end
    if (load_out) begin
      // remove the 2^16 bias: flip the top bit of the 17-bit quotient
      sample_r    <= {~quotient[wss_pkg::QUO_W-1], quotient[wss_pkg::QUO_W-2:0]};
      cycle_end_r <= end_c;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = sample_r;
  assign out_ch.cycle_end  = cycle_end_r;

  wss_table #(.AW(AW)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (in_ch.table_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  wss_mac u_mac (
    .clk  (clk),
    .cmd  (mac_cmd),
    .prod (prod),
    .acc  (acc)
  );

  wss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_c[16 +: wss_pkg::DIVD_W]),
    .divisor  (n_r),
    .busy     (div_busy),
    .quotient (quotient)
  );

endmodule

>>> src/wss_checker.sv
module wss_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic [wss_pkg::OP_W-1:0]         in_operation,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [wss_pkg::OUT_W-1:0] out_sample_out,
  input logic                             out_cycle_end
);

  // Result held while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> $stable(out_sample_out) && $stable(out_cycle_end))
    else $error("result changed while stalled");

  // A fresh result only comes out of a tick in progress, never out of idle
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
      $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while input side was idle");

  // Writes, start and stop complete without leaving the block busy
  a_ctrl_quick: assert property (@(posedge clk) disable iff (!rst_n)
      in_valid && in_ready && (in_operation != 2'(wss_pkg::OP_TICK)) |=> in_ready)
    else $error("non-tick transaction left the block busy");

  a_reset_empty: assert property (@(posedge clk)
      !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind wavetable_scan_oscillator wss_checker u_wss_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_operation   (in_ch.operation),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_sample_out (out_ch.sample_out),
  .out_cycle_end  (out_ch.cycle_end)
);
